@@ rtl/kis_pkg.sv @@
// Package for the key insertion sorter: sizes, record and memory request
// types, and the sequencer state encoding. No dependencies.
`default_nettype none

package kis_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 58;
	localparam int TAG_W    = 10;
	localparam int CMP_W    = 11;
	localparam int MOV_W    = 6;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [CMP_W-1:0]  cmp_cnt_t;
	typedef logic [MOV_W-1:0]  mov_cnt_t;

	typedef struct packed {
		key_t key;
		tag_t tag;
	} rec_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		rec_t wdata;
		logic re;
		idx_t raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

`default_nettype wire

@@ rtl/kis_in_if.sv @@
// Input channel of the key insertion sorter: valid/ready plus one record.
// Depends on kis_pkg.
`default_nettype none

interface kis_in_if;
	logic          valid;
	logic          ready;
	kis_pkg::key_t key;
	kis_pkg::tag_t tag;
	logic          final_item;

	modport source (output valid, output key, output tag, output final_item, input ready);
	modport sink   (input valid, input key, input tag, input final_item, output ready);
endinterface

`default_nettype wire

@@ rtl/kis_out_if.sv @@
// Output channel of the key insertion sorter: valid/ready plus one sorted
// record with the run statistics. Depends on kis_pkg.
`default_nettype none

interface kis_out_if;
	logic              valid;
	logic              ready;
	kis_pkg::key_t     sorted_key;
	kis_pkg::tag_t     sorted_tag;
	logic              end_of_run;
	kis_pkg::cmp_cnt_t compare_count;
	kis_pkg::mov_cnt_t move_count;
	logic              overflow;

	modport source (output valid, output sorted_key, output sorted_tag, output end_of_run,
		output compare_count, output move_count, output overflow, input ready);
	modport sink   (input valid, input sorted_key, input sorted_tag, input end_of_run,
		input compare_count, input move_count, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/key_insertion_sorter_top.sv @@
// Key insertion sorter, top level: ties the sequencer to the record store.
// Depends on kis_pkg, kis_in_if, kis_out_if, kis_store, kis_seq.
//
// Usage:
//   in_ch carries one record a beat (key, tag, final_item). Records collect
//   in ascending key order; an equal key lands before the earlier ones.
//   The beat with final_item set starts the run on out_ch: one beat per
//   stored record, ascending, end_of_run on the last, with the set's compare
//   count, move count and overflow flag on every beat. The block then
//   empties and takes the next set.
//   Insertion into an empty set is a direct write and into a full set a
//   drop; otherwise the walk compares back from the top record, shifting
//   each larger or equal one up, until it stops on a smaller key or, when
//   the record goes to the front, ends in a place step: one compare a
//   cycle over the single store read port. Up to 64 records are held;
//   later records of the set are dropped and flag overflow.
//   Each beat of the run is a store read, then an output register load.
//   in_ch.ready is high only while no insertion or run is in progress.
//   A stalled out_ch holds the current beat and pauses the run.
//   After arst_n the store is empty; no clearing pass is needed.
`default_nettype none

module key_insertion_sorter_top (
	input  wire       clk,
	input  wire       arst_n,
	kis_in_if.sink    in_ch,
	kis_out_if.source out_ch
);
	import kis_pkg::*;

	mem_req_t req;
	rec_t     rd_data;

	kis_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	kis_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

@@ rtl/kis_store.sv @@
// Record store: one write port and one registered read port over the
// sorted records. Depends on kis_pkg.
`default_nettype none

module kis_store (
	input  wire               clk,
	input  kis_pkg::mem_req_t req,
	output kis_pkg::rec_t     rd_data
);
	import kis_pkg::*;

	rec_t mem_q [CAPACITY];
	rec_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

@@ rtl/kis_seq.sv @@
// Sequencer of the key insertion sorter: walks the store back one compare a
// cycle, shifts records up, places the new one and streams the run out.
// Depends on kis_pkg, kis_in_if, kis_out_if.
`default_nettype none

module kis_seq (
	input  wire               clk,
	input  wire               arst_n,
	kis_in_if.sink            in_ch,
	kis_out_if.source         out_ch,
	output kis_pkg::mem_req_t req,
	input  kis_pkg::rec_t     rd_data
);
	import kis_pkg::*;

	state_t   state_q, state_d;
	key_t     key_q, key_d;
	tag_t     tag_q, tag_d;
	logic     final_q, final_d;
	logic     moved_q, moved_d;
	idx_t     pos_q, pos_d;
	fill_t    fill_q, fill_d;
	cmp_cnt_t cmp_q, cmp_d;
	mov_cnt_t mov_q, mov_d;
	logic     drop_q, drop_d;
	idx_t     emit_idx_q, emit_idx_d;

	logic     out_valid_q, out_valid_d;
	rec_t     out_rec_q, out_rec_d;
	logic     out_eor_q, out_eor_d;
	cmp_cnt_t out_cmp_q, out_cmp_d;
	mov_cnt_t out_mov_q, out_mov_d;
	logic     out_ovf_q, out_ovf_d;

	logic full, key_less, out_free, emit_last, emit_load;

	assign full      = (fill_q == FILL_W'(CAPACITY));
	assign key_less  = (rd_data.key < key_q);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign emit_last = ((FILL_W'(emit_idx_q) + FILL_W'(1)) == fill_q);
	assign emit_load = (state_q == ST_EMIT_LD) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (full || fill_q == '0) begin
						state_d = in_ch.final_item ? ST_EMIT_RD : ST_IDLE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (key_less) begin
					state_d = final_q ? ST_EMIT_RD : ST_IDLE;
				end else if (pos_q == idx_t'(1)) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				state_d = final_q ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				state_d = (fill_q == '0) ? ST_IDLE : ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		key_d       = key_q;
		tag_d       = tag_q;
		final_d     = final_q;
		moved_d     = moved_q;
		pos_d       = pos_q;
		fill_d      = fill_q;
		cmp_d       = cmp_q;
		mov_d       = mov_q;
		drop_d      = drop_q;
		emit_idx_d  = emit_idx_q;
		out_rec_d   = out_rec_q;
		out_eor_d   = out_eor_q;
		out_cmp_d   = out_cmp_q;
		out_mov_d   = out_mov_q;
		out_ovf_d   = out_ovf_q;
		out_valid_d = out_valid_q && !out_ch.ready;
		req         = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					key_d      = in_ch.key;
					tag_d      = in_ch.tag;
					final_d    = in_ch.final_item;
					moved_d    = 1'b0;
					emit_idx_d = '0;
					pos_d      = fill_q[IDX_W-1:0];
					if (full) begin
						drop_d = 1'b1;
					end else if (fill_q == '0) begin
						req.we    = 1'b1;
						req.waddr = '0;
						req.wdata = '{key: in_ch.key, tag: in_ch.tag};
						fill_d    = FILL_W'(1);
					end else begin
						req.re    = 1'b1;
						req.raddr = IDX_W'(fill_q - FILL_W'(1));
					end
				end
			end
			ST_WALK: begin
				cmp_d     = cmp_q + CMP_W'(1);
				req.we    = 1'b1;
				req.waddr = pos_q;
				if (key_less) begin
					req.wdata = '{key: key_q, tag: tag_q};
					fill_d    = fill_q + FILL_W'(1);
					if (moved_q) begin
						mov_d = mov_q + MOV_W'(1);
					end
				end else begin
					req.wdata = rd_data;
					pos_d     = pos_q - idx_t'(1);
					moved_d   = 1'b1;
					if (pos_q != idx_t'(1)) begin
						req.re    = 1'b1;
						req.raddr = pos_q - idx_t'(2);
					end
				end
			end
			ST_PLACE: begin
				req.we    = 1'b1;
				req.waddr = pos_q;
				req.wdata = '{key: key_q, tag: tag_q};
				fill_d    = fill_q + FILL_W'(1);
				mov_d     = mov_q + MOV_W'(1);
			end
			ST_EMIT_RD: begin
				if (fill_q == '0) begin
					cmp_d  = '0;
					mov_d  = '0;
					drop_d = 1'b0;
				end else begin
					req.re    = 1'b1;
					req.raddr = emit_idx_q;
				end
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_rec_d   = rd_data;
					out_eor_d   = emit_last;
					out_cmp_d   = cmp_q;
					out_mov_d   = mov_q;
					out_ovf_d   = drop_q;
					if (emit_last) begin
						fill_d = '0;
						cmp_d  = '0;
						mov_d  = '0;
						drop_d = 1'b0;
					end else begin
						emit_idx_d = emit_idx_q + idx_t'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cmp_q       <= '0;
			mov_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			cmp_q       <= cmp_d;
			mov_q       <= mov_d;
			drop_q      <= drop_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_d;
		tag_q      <= tag_d;
		final_q    <= final_d;
		moved_q    <= moved_d;
		pos_q      <= pos_d;
		emit_idx_q <= emit_idx_d;
		out_rec_q  <= out_rec_d;
		out_eor_q  <= out_eor_d;
		out_cmp_q  <= out_cmp_d;
		out_mov_q  <= out_mov_d;
		out_ovf_q  <= out_ovf_d;
	end

	assign in_ch.ready          = (state_q == ST_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.sorted_key    = out_rec_q.key;
	assign out_ch.sorted_tag    = out_rec_q.tag;
	assign out_ch.end_of_run    = out_eor_q;
	assign out_ch.compare_count = out_cmp_q;
	assign out_ch.move_count    = out_mov_q;
	assign out_ch.overflow      = out_ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_walk_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> pos_q != '0)
		else $error("walk with no record below the insert point");

	a_mov_bound: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(mov_q) <= fill_q)
		else $error("more moved records than stored records");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && emit_last |=> fill_q == '0 && cmp_q == '0 && !drop_q)
		else $error("set not cleared after last beat");

endmodule

`default_nettype wire
